// ===== sv/cswh_pkg.sv =====
// ----------------------------------------------------------------------------
// cswh_pkg: shared types for the case-insensitive word hash set
// Result status codes, the controller/datapath command and status bundles,
// and the ASCII lowercase helper.
// ----------------------------------------------------------------------------
package cswh_pkg;

  // Multiplier of the polynomial string hash
  localparam int unsigned HASH_MULT = 31;

  // Field widths of the result channel
  localparam int unsigned COUNT_W  = 13;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_LONG = 2'd2
  } status_t;

  // Controller to datapath
  typedef struct packed {
    logic    clr_step;   // write one empty bucket head during the clearing pass
    logic    accept;     // take one byte from the input channel
    logic    mod_step;   // advance the bucket residue reduction
    logic    head_rd;    // read the head of the current bucket
    logic    cpy_start;  // reset the copy / compare index
    logic    cpy_step;   // move one byte from the word buffer to the entry store
    logic    ins_link;   // link the new entry and count it
    logic    link_head;  // load the chain pointer from the bucket head
    logic    link_next;  // load the chain pointer from the entry's next field
    logic    ent_rd;     // read length and next of the pointed entry
    logic    cmp_rd;     // read one stored byte and one buffer byte
    logic    cmp_next;   // advance the compare index
    logic    res_load;   // load the result register, end the word
    logic    res_found;
    status_t res_status;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_done;
    logic mod_done;
    logic last;
    logic func;
    logic too_long;
    logic full;
    logic cpy_done;
    logic link_zero;
    logic len_eq;
    logic char_eq;
    logic cmp_last;
    logic out_free;
  } sts_t;

  // Lowercase ASCII letters, keep every other byte
  function automatic logic [7:0] lower_byte(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

// ===== sv/cswh_ifs.sv =====
// ----------------------------------------------------------------------------
// cswh channel interfaces
// Valid/ready channels for incoming word bytes and outgoing results.
// ----------------------------------------------------------------------------
interface cswh_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] byte_in;
  logic       last;

  modport source (output valid, func, byte_in, last, input ready);
  modport sink   (input valid, func, byte_in, last, output ready);
endinterface

interface cswh_out_if;
  logic                           valid;
  logic                           ready;
  logic                           found;
  logic [cswh_pkg::STATUS_W-1:0]  status;
  logic [cswh_pkg::COUNT_W-1:0]   word_count;

  modport source (output valid, found, status, word_count, input ready);
  modport sink   (input valid, found, status, word_count, output ready);
endinterface

// ===== sv/cswh_ctrl.sv =====
// ----------------------------------------------------------------------------
// cswh_ctrl: sequencer of the word hash set
// Clears the bucket heads after reset, then steps each word's last byte through the
// hash reduction and each finished word through insert or chain walk, unless it is too long or meets a full store.
// ----------------------------------------------------------------------------
module cswh_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  cswh_pkg::sts_t  sts,
  output cswh_pkg::cmd_t  cmd
);

  typedef enum logic [12:0] {
    S_CLEAR    = 13'b0000000000001,
    S_IDLE     = 13'b0000000000010,
    S_HASH     = 13'b0000000000100,
    S_INS_HEAD = 13'b0000000001000,
    S_INS_COPY = 13'b0000000010000,
    S_INS_LINK = 13'b0000000100000,
    S_CHK_HEAD = 13'b0000001000000,
    S_CHK_LOAD = 13'b0000010000000,
    S_CHK_ENT  = 13'b0000100000000,
    S_CHK_LEN  = 13'b0001000000000,
    S_CMP_RD   = 13'b0010000000000,
    S_CMP_EQ   = 13'b0100000000000,
    S_RESULT   = 13'b1000000000000
  } state_t;

  state_t              state_r, state_nxt;
  cswh_pkg::status_t   stat_r, stat_nxt;
  logic                found_r, found_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    stat_nxt  = stat_r;
    found_nxt = found_r;
    cmd       = '0;
    cmd.res_found  = found_r;
    cmd.res_status = stat_r;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        found_nxt = 1'b0;
        stat_nxt  = cswh_pkg::STAT_OK;
        if (!sts.mod_done) begin
          cmd.mod_step = 1'b1;
        end else begin
          priority if (!sts.last) begin
            state_nxt = S_IDLE;
          end else if (sts.too_long) begin
            stat_nxt  = cswh_pkg::STAT_LONG;
            state_nxt = S_RESULT;
          end else if (!sts.func && sts.full) begin
            stat_nxt  = cswh_pkg::STAT_FULL;
            state_nxt = S_RESULT;
          end else if (!sts.func) begin
            state_nxt = S_INS_HEAD;
          end else begin
            state_nxt = S_CHK_HEAD;
          end
        end
      end
      S_INS_HEAD: begin
        cmd.head_rd   = 1'b1;
        cmd.cpy_start = 1'b1;
        state_nxt     = S_INS_COPY;
      end
      S_INS_COPY: begin
        cmd.cpy_step = 1'b1;
        if (sts.cpy_done) begin
          state_nxt = S_INS_LINK;
        end
      end
      S_INS_LINK: begin
        cmd.ins_link = 1'b1;
        state_nxt    = S_RESULT;
      end
      S_CHK_HEAD: begin
        cmd.head_rd = 1'b1;
        state_nxt   = S_CHK_LOAD;
      end
      S_CHK_LOAD: begin
        cmd.link_head = 1'b1;
        state_nxt     = S_CHK_ENT;
      end
      S_CHK_ENT: begin
        if (sts.link_zero) begin
          state_nxt = S_RESULT;
        end else begin
          cmd.ent_rd = 1'b1;
          state_nxt  = S_CHK_LEN;
        end
      end
      S_CHK_LEN: begin
        if (sts.len_eq) begin
          cmd.cpy_start = 1'b1;
          state_nxt     = S_CMP_RD;
        end else begin
          cmd.link_next = 1'b1;
          state_nxt     = S_CHK_ENT;
        end
      end
      S_CMP_RD: begin
        cmd.cmp_rd = 1'b1;
        state_nxt  = S_CMP_EQ;
      end
      S_CMP_EQ: begin
        priority if (!sts.char_eq) begin
          cmd.link_next = 1'b1;
          state_nxt     = S_CHK_ENT;
        end else if (sts.cmp_last) begin
          found_nxt = 1'b1;
          state_nxt = S_RESULT;
        end else begin
          cmd.cmp_next = 1'b1;
          state_nxt    = S_CMP_RD;
        end
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // Hold state and pending result code
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      stat_r  <= cswh_pkg::STAT_OK;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      stat_r  <= stat_nxt;
      found_r <= found_nxt;
    end
  end

endmodule

// ===== sv/cswh_dp.sv =====
// ----------------------------------------------------------------------------
// cswh_dp: datapath of the word hash set
// Word buffer, running hash and its bucket reduction, bucket head / entry
// memories, copy and compare indexes, and the result register.
// ----------------------------------------------------------------------------
module cswh_dp #(
  parameter int BUCKETS      = 4096,
  parameter int MAX_ENTRIES  = 4096,
  parameter int MAX_WORD_LEN = 45
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  cswh_pkg::cmd_t                 cmd,
  output cswh_pkg::sts_t                 sts,
  input  logic                           in_func,
  input  logic [7:0]                     in_byte,
  input  logic                           in_last,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_found,
  output logic [cswh_pkg::STATUS_W-1:0]  out_status,
  output logic [cswh_pkg::COUNT_W-1:0]   out_count
);

  localparam int BW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int IW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int EW  = $clog2(MAX_ENTRIES + 1);
  localparam int XW  = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
  localparam int LW  = $clog2(MAX_WORD_LEN + 1);
  localparam int NCH = MAX_ENTRIES * MAX_WORD_LEN;
  localparam int CW  = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int YP  = 32;
  localparam int SPC = 8;
  localparam int MC  = YP / SPC;
  localparam int MW  = $clog2(MC + 1);

  localparam logic [BW:0]    BKT       = (BW+1)'(BUCKETS);
  localparam logic [BW-1:0]  BKT_LAST  = BW'(BUCKETS - 1);
  localparam logic [LW-1:0]  LEN_MAX   = LW'(MAX_WORD_LEN);
  localparam logic [EW-1:0]  ENT_MAX   = EW'(MAX_ENTRIES);
  localparam logic [CW-1:0]  CH_STRIDE = CW'(MAX_WORD_LEN);
  localparam logic [MW-1:0]  MOD_CYC   = MW'(MC);

  // Memories
  logic [EW-1:0] head_mem [BUCKETS];
  logic [EW-1:0] next_mem [MAX_ENTRIES];
  logic [LW-1:0] len_mem  [MAX_ENTRIES];
  logic [7:0]    char_mem [NCH];
  logic [7:0]    wbuf_mem [MAX_WORD_LEN];

  logic [EW-1:0] head_q, next_q;
  logic [LW-1:0] len_q;
  logic [7:0]    char_q, wbuf_q;

  // Control and payload registers
  logic [BW-1:0] res_r, res_nxt;
  logic [YP-1:0] hash_r, hash_nxt;
  logic [YP-1:0] y_r;
  logic [MW-1:0] mcnt_r;
  logic [LW-1:0] wlen_r;
  logic          too_long_r, last_r, func_r;
  logic [EW-1:0] used_r;
  logic [CW-1:0] ins_base_r, base_r;
  logic [BW-1:0] clr_idx_r;
  logic [EW-1:0] link_r;
  logic [LW-1:0] idx_r, widx_r;
  logic          wpend_r;
  logic          out_valid_r, found_r;
  logic [cswh_pkg::STATUS_W-1:0] status_r;
  logic [cswh_pkg::COUNT_W-1:0]  count_r;

  logic [IW-1:0] ent_idx, used_idx;
  logic          cpy_rd;

  assign ent_idx  = IW'(link_r - EW'(1));
  assign used_idx = used_r[IW-1:0];
  assign hash_nxt = hash_r * YP'(cswh_pkg::HASH_MULT)
                  + YP'(cswh_pkg::lower_byte(in_byte));
  assign cpy_rd   = cmd.cpy_step && (idx_r != wlen_r);

  // Reduce the 32-bit hash modulo the bucket count, eight bits per step
  always_comb begin
    logic [BW:0]   rem;
    logic [BW:0]   t;
    logic [YP-1:0] ys;
    rem = {1'b0, res_r};
    ys  = y_r;
    for (int k = 0; k < SPC; k++) begin
      t = {rem[BW-1:0], ys[YP-1]};
      if (t >= BKT) begin
        t = t - BKT;
      end
      rem = t;
      ys  = ys << 1;
    end
    res_nxt = rem[BW-1:0];
  end

  // Byte intake, running hash, bucket residue and word bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r      <= '0;
      hash_r     <= '0;
      mcnt_r     <= '0;
      wlen_r     <= '0;
      too_long_r <= 1'b0;
      last_r     <= 1'b0;
      func_r     <= 1'b0;
    end else begin
      if (cmd.accept) begin
        res_r  <= '0;
        hash_r <= hash_nxt;
        mcnt_r <= in_last ? MOD_CYC : '0;
        last_r <= in_last;
        func_r <= in_func;
        if (wlen_r < LEN_MAX) begin
          wlen_r <= wlen_r + LW'(1);
        end else begin
          too_long_r <= 1'b1;
        end
      end else if (cmd.mod_step) begin
        res_r  <= res_nxt;
        mcnt_r <= mcnt_r - MW'(1);
      end else if (cmd.res_load) begin
        res_r      <= '0;
        hash_r     <= '0;
        wlen_r     <= '0;
        too_long_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      y_r <= hash_nxt;
    end else if (cmd.mod_step) begin
      y_r <= y_r << SPC;
    end
  end

  // Word buffer
  always_ff @(posedge clk) begin
    if (cmd.accept && wlen_r < LEN_MAX) begin
      wbuf_mem[wlen_r[XW-1:0]] <= in_byte;
    end
    if (cpy_rd || cmd.cmp_rd) begin
      wbuf_q <= wbuf_mem[idx_r[XW-1:0]];
    end
  end

  // Bucket heads: clearing pass, insert link, lookup
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      head_mem[clr_idx_r] <= '0;
    end else if (cmd.ins_link) begin
      head_mem[res_r] <= used_r + EW'(1);
    end
    if (cmd.head_rd) begin
      head_q <= head_mem[res_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
    end else if (cmd.clr_step && clr_idx_r != BKT_LAST) begin
      clr_idx_r <= clr_idx_r + BW'(1);
    end
  end

  // Entry next and length
  always_ff @(posedge clk) begin
    if (cmd.ins_link) begin
      next_mem[used_idx] <= head_q;
      len_mem[used_idx]  <= wlen_r;
    end
    if (cmd.ent_rd) begin
      next_q <= next_mem[ent_idx];
      len_q  <= len_mem[ent_idx];
    end
  end

  // Entry bytes
  always_ff @(posedge clk) begin
    if (cmd.cpy_step && wpend_r) begin
      char_mem[ins_base_r + CW'(widx_r)] <= wbuf_q;
    end
    if (cmd.cmp_rd) begin
      char_q <= char_mem[base_r + CW'(idx_r)];
    end
  end

  // Entry count and insert base
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r     <= '0;
      ins_base_r <= '0;
    end else if (cmd.ins_link) begin
      used_r     <= used_r + EW'(1);
      ins_base_r <= ins_base_r + CH_STRIDE;
    end
  end

  // Copy / compare index and chain pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      wpend_r <= 1'b0;
      link_r  <= '0;
    end else begin
      if (cmd.cpy_start) begin
        idx_r   <= '0;
        wpend_r <= 1'b0;
      end else if (cmd.cpy_step) begin
        wpend_r <= cpy_rd;
        if (cpy_rd) begin
          idx_r <= idx_r + LW'(1);
        end
      end else if (cmd.cmp_next) begin
        idx_r <= idx_r + LW'(1);
      end
      if (cmd.link_head) begin
        link_r <= head_q;
      end else if (cmd.link_next) begin
        link_r <= next_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cpy_rd) begin
      widx_r <= idx_r;
    end
    if (cmd.ent_rd) begin
      base_r <= CW'(ent_idx) * CH_STRIDE;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      found_r  <= cmd.res_found;
      status_r <= cmd.res_status;
      count_r  <= cswh_pkg::COUNT_W'(used_r);
    end
  end

  assign out_valid  = out_valid_r;
  assign out_found  = found_r;
  assign out_status = status_r;
  assign out_count  = count_r;

  // Status to the controller
  always_comb begin
    sts.clr_done  = (clr_idx_r == BKT_LAST);
    sts.mod_done  = (mcnt_r == '0);
    sts.last      = last_r;
    sts.func      = func_r;
    sts.too_long  = too_long_r;
    sts.full      = (used_r >= ENT_MAX);
    sts.cpy_done  = (idx_r == wlen_r) && !wpend_r;
    sts.link_zero = (link_r == '0);
    sts.len_eq    = (len_q == wlen_r);
    sts.char_eq   = (cswh_pkg::lower_byte(char_q) == cswh_pkg::lower_byte(wbuf_q));
    sts.cmp_last  = ((LW+1)'(idx_r) + (LW+1)'(1)) == (LW+1)'(wlen_r);
    sts.out_free  = !out_valid_r || out_ready;
  end

endmodule

// ===== sv/case_insensitive_word_hash_set_core.sv =====
// ----------------------------------------------------------------------------
// case_insensitive_word_hash_set_core
// Chained hash set of words, fed one byte per transfer; each word gives
// one result: inserted, found / not found, table full or word too long.
//
//   channel  dir  handshake          payload
//   in_ch    in   valid / ready      func, byte_in, last
//   out_ch   out  valid / ready      found, status, word_count
//
// After reset a clearing pass writes every bucket head, with in_ch.ready low.
// A last byte has the 32-bit hash reduced to its bucket 8 bits per cycle.
// An insert then copies the word into the entry store and links the entry;
// a check walks the bucket chain, comparing lengths and then bytes; a too
// long word or a full store goes straight to the result. Bytes are taken
// while a result waits; a finished word stalls only while the result
// register is full.
// ----------------------------------------------------------------------------
module case_insensitive_word_hash_set_core #(
  parameter int BUCKETS      = 4096,
  parameter int MAX_ENTRIES  = 4096,
  parameter int MAX_WORD_LEN = 45
) (
  input  logic              clk,
  input  logic              rst_n,
  cswh_in_if.sink           in_ch,
  cswh_out_if.source        out_ch
);

  cswh_pkg::cmd_t cmd;
  cswh_pkg::sts_t sts;

  cswh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cswh_dp #(
    .BUCKETS      (BUCKETS),
    .MAX_ENTRIES  (MAX_ENTRIES),
    .MAX_WORD_LEN (MAX_WORD_LEN)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_func    (in_ch.func),
    .in_byte    (in_ch.byte_in),
    .in_last    (in_ch.last),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_found  (out_ch.found),
    .out_status (out_ch.status),
    .out_count  (out_ch.word_count)
  );

  // Load a result only into a free output register
  a_res_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |-> sts.out_free)
    else $error("result loaded over an untaken result");

  // Never link an entry into a full store
  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins_link |-> !sts.full)
    else $error("insert linked with the entry store full");

  // Never read an entry through an empty chain pointer
  a_link_live: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ent_rd |-> !sts.link_zero)
    else $error("entry read through an empty link");

  // A byte transfer and a result load never share a cycle
  a_accept_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |-> !cmd.res_load)
    else $error("byte accepted during result load");

endmodule
